// ===== design/lps_pkg.sv =====
// Shared types, constants and helper functions for the line pixel stepper.
// Depends on nothing; every other design file refers to it by scoped names.
package lps_pkg;

  // Coordinate width; the error term and the pixel count carry one more bit.
  localparam int COORD_W = 12;
  localparam int ERR_W   = COORD_W + 1;

  // Configuration register widths and the shared write-data width.
  localparam int BASE_W   = 32;
  localparam int PITCH_W  = 16;
  localparam int BPP_W    = 3;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 2;
  localparam int COLOR_W  = 24;
  localparam int ADDR_W   = 32;

  // Reset value of bytes per pixel.
  localparam logic [BPP_W-1:0] BPP_RESET = BPP_W'(3);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FB_BASE   = 2'd0,
    CFG_ROW_PITCH = 2'd1,
    CFG_BPP       = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    REQ_START   = 1'b0,
    REQ_ADVANCE = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    MODE_HORIZ  = 2'd0,
    MODE_VERT   = 2'd1,
    MODE_XMAJOR = 2'd2,
    MODE_YMAJOR = 2'd3
  } line_mode_t;

  typedef struct packed {
    logic               req_type;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
    logic [COLOR_W-1:0] line_color;
  } lps_in_t;

  typedef struct packed {
    logic               pixel_valid;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [ADDR_W-1:0]  byte_address;
    logic [COLOR_W-1:0] pixel_color;
    logic               last_pixel;
    logic               line_active;
  } lps_out_t;

  // Pixel stage between the walker and the address unit.
  typedef struct packed {
    logic               stage_valid;
    logic               pixel_valid;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [COLOR_W-1:0] pixel_color;
    logic               last_pixel;
    logic               line_active;
  } lps_pix_t;

  typedef struct packed {
    logic [BASE_W-1:0]  fb_base;
    logic [PITCH_W-1:0] row_pitch;
    logic [BPP_W-1:0]   bytes_per_pixel;
  } lps_cfg_t;

  // One coordinate step toward the end point, wrapping at the coordinate width.
  function automatic logic [COORD_W-1:0] step_coord(input logic [COORD_W-1:0] v,
                                                    input logic neg);
    step_coord = neg ? v - COORD_W'(1) : v + COORD_W'(1);
  endfunction

endpackage

// ===== design/lps_walker.sv =====
// Line walker: holds the line state, performs one start or Bresenham step
// per item and registers the resulting pixel. Uses lps_pkg.
module lps_walker (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            item_valid,
  input  lps_pkg::lps_in_t item,
  input  logic            down_ready,
  output logic            take,
  output logic            walk_ready,
  output lps_pkg::lps_pix_t pix_r
);

  logic [lps_pkg::COORD_W-1:0] cur_x_r, cur_x_nxt;
  logic [lps_pkg::COORD_W-1:0] cur_y_r, cur_y_nxt;
  logic [lps_pkg::COORD_W-1:0] abs_dx_r, abs_dx_nxt;
  logic [lps_pkg::COORD_W-1:0] abs_dy_r, abs_dy_nxt;
  logic                        step_x_neg_r, step_x_neg_nxt;
  logic                        step_y_neg_r, step_y_neg_nxt;
  logic [lps_pkg::ERR_W-1:0]   err_accum_r, err_accum_nxt;
  logic [lps_pkg::ERR_W-1:0]   pixels_left_r, pixels_left_nxt;
  lps_pkg::line_mode_t         line_mode_r, line_mode_nxt;
  logic [lps_pkg::COLOR_W-1:0] held_color_r, held_color_nxt;
  logic                        busy_r, busy_nxt;
  lps_pkg::lps_pix_t           pix_nxt;

  logic                        sx_neg, sy_neg;
  logic [lps_pkg::COORD_W-1:0] sdx, sdy;
  logic [lps_pkg::ERR_W-1:0]   err_x_sum, err_y_sum;

  assign walk_ready = !pix_r.stage_valid || down_ready;
  assign take       = item_valid && walk_ready;

  // Start-item geometry.
  assign sx_neg = item.end_x < item.start_x;
  assign sy_neg = item.end_y < item.start_y;
  assign sdx    = sx_neg ? item.start_x - item.end_x : item.end_x - item.start_x;
  assign sdy    = sy_neg ? item.start_y - item.end_y : item.end_y - item.start_y;

  // Error accumulation for the two diagonal modes.
  assign err_x_sum = err_accum_r + {1'b0, abs_dy_r};
  assign err_y_sum = err_accum_r + {1'b0, abs_dx_r};

  always_comb begin
    cur_x_nxt       = cur_x_r;
    cur_y_nxt       = cur_y_r;
    abs_dx_nxt      = abs_dx_r;
    abs_dy_nxt      = abs_dy_r;
    step_x_neg_nxt  = step_x_neg_r;
    step_y_neg_nxt  = step_y_neg_r;
    err_accum_nxt   = err_accum_r;
    pixels_left_nxt = pixels_left_r;
    line_mode_nxt   = line_mode_r;
    held_color_nxt  = held_color_r;
    busy_nxt        = busy_r;

    if (item.req_type == lps_pkg::REQ_START) begin
      cur_x_nxt      = item.start_x;
      cur_y_nxt      = item.start_y;
      step_x_neg_nxt = sx_neg;
      step_y_neg_nxt = sy_neg;
      abs_dx_nxt     = sdx;
      abs_dy_nxt     = sdy;
      held_color_nxt = item.line_color;
      priority if (sdy == '0) begin
        line_mode_nxt   = lps_pkg::MODE_HORIZ;
        pixels_left_nxt = {1'b0, sdx};
        err_accum_nxt   = '0;
      end else if (sdx == '0) begin
        line_mode_nxt   = lps_pkg::MODE_VERT;
        pixels_left_nxt = {1'b0, sdy};
        err_accum_nxt   = '0;
      end else if (sdx >= sdy) begin
        line_mode_nxt   = lps_pkg::MODE_XMAJOR;
        pixels_left_nxt = {1'b0, sdx};
        err_accum_nxt   = {2'b00, sdx[lps_pkg::COORD_W-1:1]};
      end else begin
        line_mode_nxt   = lps_pkg::MODE_YMAJOR;
        pixels_left_nxt = {1'b0, sdy};
        err_accum_nxt   = {2'b00, sdy[lps_pkg::COORD_W-1:1]};
      end
      busy_nxt = pixels_left_nxt != '0;
    end else if (busy_r) begin
      unique case (line_mode_r)
        lps_pkg::MODE_HORIZ: begin
          cur_x_nxt = lps_pkg::step_coord(cur_x_r, step_x_neg_r);
        end
        lps_pkg::MODE_VERT: begin
          cur_y_nxt = lps_pkg::step_coord(cur_y_r, step_y_neg_r);
        end
        lps_pkg::MODE_XMAJOR: begin
          err_accum_nxt = err_x_sum;
          if (err_x_sum >= {1'b0, abs_dx_r}) begin
            err_accum_nxt = err_x_sum - {1'b0, abs_dx_r};
            cur_y_nxt     = lps_pkg::step_coord(cur_y_r, step_y_neg_r);
          end
          cur_x_nxt = lps_pkg::step_coord(cur_x_r, step_x_neg_r);
        end
        lps_pkg::MODE_YMAJOR: begin
          err_accum_nxt = err_y_sum;
          if (err_y_sum >= {1'b0, abs_dy_r}) begin
            err_accum_nxt = err_y_sum - {1'b0, abs_dy_r};
            cur_x_nxt     = lps_pkg::step_coord(cur_x_r, step_x_neg_r);
          end
          cur_y_nxt = lps_pkg::step_coord(cur_y_r, step_y_neg_r);
        end
        default: begin
          cur_x_nxt = cur_x_r;
        end
      endcase
      pixels_left_nxt = pixels_left_r - lps_pkg::ERR_W'(1);
      busy_nxt        = pixels_left_nxt != '0;
    end
  end

  // Pixel carried by this item: the old position for straight lines, the
  // stepped position for diagonal walks.
  always_comb begin
    pix_nxt             = '0;
    pix_nxt.stage_valid = 1'b1;
    pix_nxt.line_active = busy_nxt;
    if (item.req_type == lps_pkg::REQ_ADVANCE && busy_r) begin
      pix_nxt.pixel_valid = 1'b1;
      pix_nxt.pixel_color = held_color_r;
      pix_nxt.last_pixel  = !busy_nxt;
      if (line_mode_r == lps_pkg::MODE_HORIZ || line_mode_r == lps_pkg::MODE_VERT) begin
        pix_nxt.pixel_x = cur_x_r;
        pix_nxt.pixel_y = cur_y_r;
      end else begin
        pix_nxt.pixel_x = cur_x_nxt;
        pix_nxt.pixel_y = cur_y_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r       <= '0;
      cur_y_r       <= '0;
      abs_dx_r      <= '0;
      abs_dy_r      <= '0;
      step_x_neg_r  <= 1'b0;
      step_y_neg_r  <= 1'b0;
      err_accum_r   <= '0;
      pixels_left_r <= '0;
      line_mode_r   <= lps_pkg::MODE_HORIZ;
      held_color_r  <= '0;
      busy_r        <= 1'b0;
    end else if (take) begin
      cur_x_r       <= cur_x_nxt;
      cur_y_r       <= cur_y_nxt;
      abs_dx_r      <= abs_dx_nxt;
      abs_dy_r      <= abs_dy_nxt;
      step_x_neg_r  <= step_x_neg_nxt;
      step_y_neg_r  <= step_y_neg_nxt;
      err_accum_r   <= err_accum_nxt;
      pixels_left_r <= pixels_left_nxt;
      line_mode_r   <= line_mode_nxt;
      held_color_r  <= held_color_nxt;
      busy_r        <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_r <= '0;
    end else if (take) begin
      pix_r <= pix_nxt;
    end else if (down_ready) begin
      pix_r.stage_valid <= 1'b0;
    end
  end

endmodule

// ===== design/lps_addr.sv =====
// Address stage: forms the framebuffer byte address of a pixel and holds the
// finished result in the output register. Uses lps_pkg.
module lps_addr (
  input  logic              clk,
  input  logic              rst_n,
  input  lps_pkg::lps_pix_t pix,
  input  lps_pkg::lps_cfg_t cfg,
  input  logic              out_ready,
  output logic              addr_ready,
  output logic              out_valid_r,
  output lps_pkg::lps_out_t out_item_r
);

  logic [lps_pkg::COORD_W+lps_pkg::PITCH_W-1:0] row_off;
  logic [lps_pkg::COORD_W+lps_pkg::BPP_W-1:0]   col_off;
  logic [lps_pkg::ADDR_W-1:0]                   addr_sum;
  lps_pkg::lps_out_t                            out_nxt;
  logic                                         load;

  assign addr_ready = !out_valid_r || out_ready;
  assign load       = pix.stage_valid && addr_ready;

  assign row_off  = pix.pixel_y * cfg.row_pitch;
  assign col_off  = pix.pixel_x * cfg.bytes_per_pixel;
  assign addr_sum = cfg.fb_base + lps_pkg::ADDR_W'(row_off) + lps_pkg::ADDR_W'(col_off);

  always_comb begin
    out_nxt.pixel_valid  = pix.pixel_valid;
    out_nxt.pixel_x      = pix.pixel_x;
    out_nxt.pixel_y      = pix.pixel_y;
    out_nxt.byte_address = pix.pixel_valid ? addr_sum : '0;
    out_nxt.pixel_color  = pix.pixel_color;
    out_nxt.last_pixel   = pix.last_pixel;
    out_nxt.line_active  = pix.line_active;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item_r <= out_nxt;
    end
  end

endmodule

// ===== design/line_pixel_stepper.sv =====
// Top level of the line pixel stepper: input register, configuration
// registers, and the walker and address stages. Uses lps_pkg, lps_walker, lps_addr.
//
//   Channel   Ports                                   Direction  Handshake
//   ------    --------------------------------------  ---------  -------------
//   input     in_valid, in_ready, in_item              in         valid/ready
//   result    out_valid, out_ready, out_item           out        valid/ready
//   config    cfg_we, cfg_index, cfg_wdata             in         write enable
//
// Every item, start or advance, yields exactly one result item. An item passes
// three registers (input, pixel, result) before its result item is presented.
// One item per cycle is sustained when out_ready is high.
// The walker's line state updates as an item leaves the input register, so the
// next item always sees the line as the previous one left it.
// Reset is synchronous and active low; it clears the line state and loads the
// register defaults (base 0, pitch 0, three bytes per pixel).
// The ready signals chain combinationally from out_ready, so during a result
// stall an empty register still takes an item, and in_ready falls in the same
// cycle once all three registers are full.
module line_pixel_stepper (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  lps_pkg::lps_in_t              in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output lps_pkg::lps_out_t             out_item,
  input  logic                          cfg_we,
  input  logic [lps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lps_pkg::CFG_W-1:0]     cfg_wdata
);

  // Input register stage.
  logic              in_v_r;
  lps_pkg::lps_in_t  in_item_r;

  // Configuration registers, gathered into one struct for the address stage.
  lps_pkg::lps_cfg_t cfg_r;

  logic              take;
  logic              walk_ready;
  logic              addr_ready;
  lps_pkg::lps_pix_t pix_r;

  // The input register frees up when its item moves on to the walker.
  assign in_ready = !in_v_r || walk_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_v_r <= 1'b1;
    end else if (take) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_item;
    end
  end

  // Register writes; an index past the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fb_base         <= '0;
      cfg_r.row_pitch       <= '0;
      cfg_r.bytes_per_pixel <= lps_pkg::BPP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lps_pkg::CFG_FB_BASE: begin
          cfg_r.fb_base <= cfg_wdata[lps_pkg::BASE_W-1:0];
        end
        lps_pkg::CFG_ROW_PITCH: begin
          cfg_r.row_pitch <= cfg_wdata[lps_pkg::PITCH_W-1:0];
        end
        lps_pkg::CFG_BPP: begin
          cfg_r.bytes_per_pixel <= cfg_wdata[lps_pkg::BPP_W-1:0];
        end
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  // Start and step logic; owns the line state and the pixel register.
  lps_walker u_walker (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_v_r),
    .item       (in_item_r),
    .down_ready (addr_ready),
    .take       (take),
    .walk_ready (walk_ready),
    .pix_r      (pix_r)
  );

  // Byte address multiply-add and the result register.
  lps_addr u_addr (
    .clk         (clk),
    .rst_n       (rst_n),
    .pix         (pix_r),
    .cfg         (cfg_r),
    .out_ready   (out_ready),
    .addr_ready  (addr_ready),
    .out_valid_r (out_valid),
    .out_item_r  (out_item)
  );

endmodule

// ===== test/lps_checker.sv =====
// Scoreboard for the line pixel stepper: mirrors the line walk and the register
// file, predicts one result item per accepted item and checks every result item.
// Depends on lps_pkg for the item types, the register indexes and the modes.
module lps_checker
  import lps_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  lps_in_t              in_item,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  lps_out_t             out_item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output int                   fail_count,
  output int                   pending
);

  // Register file copy.
  logic [BASE_W-1:0]  reg_base;
  logic [PITCH_W-1:0] reg_pitch;
  logic [BPP_W-1:0]   reg_bpp;

  // Line walk copy.
  logic [COORD_W-1:0] walk_x;
  logic [COORD_W-1:0] walk_y;
  logic [COORD_W-1:0] span_x;
  logic [COORD_W-1:0] span_y;
  logic               x_neg;
  logic               y_neg;
  logic [ERR_W-1:0]   walk_err;
  logic [ERR_W-1:0]   pixels_owed;
  line_mode_t         walk_mode;
  logic [COLOR_W-1:0] walk_color;
  logic               walking;

  lps_out_t expected_pixels[$];

  function automatic logic [COORD_W-1:0] nudge(input logic [COORD_W-1:0] v,
                                               input logic neg);
    return neg ? v - 1'b1 : v + 1'b1;
  endfunction

  // Applies one item to the line walk and returns the result item it causes.
  task automatic rasterize_item(input lps_in_t it, output lps_out_t res);
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    res = '0;
    px = '0;
    py = '0;
    if (it.req_type == REQ_START) begin
      walk_x     = it.start_x;
      walk_y     = it.start_y;
      x_neg      = it.end_x < it.start_x;
      y_neg      = it.end_y < it.start_y;
      span_x     = x_neg ? it.start_x - it.end_x : it.end_x - it.start_x;
      span_y     = y_neg ? it.start_y - it.end_y : it.end_y - it.start_y;
      walk_color = it.line_color;
      if (span_y == '0) begin
        walk_mode   = MODE_HORIZ;
        pixels_owed = ERR_W'(span_x);
        walk_err    = '0;
      end else if (span_x == '0) begin
        walk_mode   = MODE_VERT;
        pixels_owed = ERR_W'(span_y);
        walk_err    = '0;
      end else if (span_x >= span_y) begin
        walk_mode   = MODE_XMAJOR;
        pixels_owed = ERR_W'(span_x);
        walk_err    = ERR_W'(span_x >> 1);
      end else begin
        walk_mode   = MODE_YMAJOR;
        pixels_owed = ERR_W'(span_y);
        walk_err    = ERR_W'(span_y >> 1);
      end
      walking = pixels_owed != '0;
    end else if (walking) begin
      case (walk_mode)
        MODE_HORIZ: begin
          px = walk_x;
          py = walk_y;
          walk_x = nudge(walk_x, x_neg);
        end
        MODE_VERT: begin
          px = walk_x;
          py = walk_y;
          walk_y = nudge(walk_y, y_neg);
        end
        MODE_XMAJOR: begin
          walk_err = walk_err + ERR_W'(span_y);
          if (walk_err >= ERR_W'(span_x)) begin
            walk_err = walk_err - ERR_W'(span_x);
            walk_y = nudge(walk_y, y_neg);
          end
          walk_x = nudge(walk_x, x_neg);
          px = walk_x;
          py = walk_y;
        end
        default: begin
          walk_err = walk_err + ERR_W'(span_x);
          if (walk_err >= ERR_W'(span_y)) begin
            walk_err = walk_err - ERR_W'(span_y);
            walk_x = nudge(walk_x, x_neg);
          end
          walk_y = nudge(walk_y, y_neg);
          px = walk_x;
          py = walk_y;
        end
      endcase
      res.pixel_valid  = 1'b1;
      res.pixel_x      = px;
      res.pixel_y      = py;
      res.pixel_color  = walk_color;
      res.byte_address = reg_base + ADDR_W'(py) * ADDR_W'(reg_pitch)
                         + ADDR_W'(px) * ADDR_W'(reg_bpp);
      pixels_owed = pixels_owed - 1'b1;
      if (pixels_owed == '0) begin
        res.last_pixel = 1'b1;
        walking = 1'b0;
      end
    end
    res.line_active = walking;
  endtask

  task automatic check_field(input string name, input logic [ADDR_W-1:0] want,
                             input logic [ADDR_W-1:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= 10)
        $display("mismatch on %0s: expected %0h, got %0h", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    lps_out_t want;
    if (!rst_n) begin
      reg_base    = '0;
      reg_pitch   = '0;
      reg_bpp     = BPP_RESET;
      walk_x      = '0;
      walk_y      = '0;
      span_x      = '0;
      span_y      = '0;
      x_neg       = 1'b0;
      y_neg       = 1'b0;
      walk_err    = '0;
      pixels_owed = '0;
      walk_mode   = MODE_HORIZ;
      walk_color  = '0;
      walking     = 1'b0;
      expected_pixels.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FB_BASE:   reg_base  = cfg_wdata[BASE_W-1:0];
          CFG_ROW_PITCH: reg_pitch = cfg_wdata[PITCH_W-1:0];
          CFG_BPP:       reg_bpp   = cfg_wdata[BPP_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        rasterize_item(in_item, want);
        expected_pixels.push_back(want);
      end
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("result item %0h arrived with nothing expected", out_item);
        end else begin
          want = expected_pixels.pop_front();
          check_field("pixel_valid", ADDR_W'(want.pixel_valid),
                      ADDR_W'(out_item.pixel_valid));
          check_field("pixel_x", ADDR_W'(want.pixel_x), ADDR_W'(out_item.pixel_x));
          check_field("pixel_y", ADDR_W'(want.pixel_y), ADDR_W'(out_item.pixel_y));
          check_field("byte_address", want.byte_address, out_item.byte_address);
          check_field("pixel_color", ADDR_W'(want.pixel_color),
                      ADDR_W'(out_item.pixel_color));
          check_field("last_pixel", ADDR_W'(want.last_pixel),
                      ADDR_W'(out_item.last_pixel));
          check_field("line_active", ADDR_W'(want.line_active),
                      ADDR_W'(out_item.line_active));
        end
      end
    end
    pending <= expected_pixels.size();
  end

endmodule

// ===== test/testbench.sv =====
// Top of the line pixel stepper test: clock, reset, stimulus on the input and
// configuration ports, and the final verdict. Needs lps_pkg, the block itself
// and lps_checker, which does all prediction and comparison.
module testbench;
  import lps_pkg::*;

  // The block has three registers between acceptance and its result item.
  localparam int LATENCY         = 3;
  localparam int SETTLE_CYCLES   = LATENCY + 5;
  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 171;
  // The slowest correct run is roughly 1100 items at the longest idle gaps on each
  // side plus the pipeline; the limit is several times that.
  localparam int CYCLE_LIMIT     = 300000;
  localparam int COORD_MAX       = (1 << COORD_W) - 1;
  // Index 3 has no register behind it; writes there must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  lps_in_t              in_item;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  lps_out_t             out_item;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  int fail_count;
  int pending;
  int cycle_count = 0;
  int items_sent = 0;

  // While a side is calm it never idles, so back-to-back items and results
  // are exercised as well as the random gaps.
  logic in_calm = 1'b0;
  logic out_calm = 1'b0;
  logic took_result = 1'b0;
  int   stall_left = 0;

  line_pixel_stepper u_top (.*);

  lps_checker u_checker (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Result side: after every accepted result item a new stall length is
  // drawn, and out_ready stays low while it counts down, then rises again.
  always @(posedge clk) took_result <= out_valid && out_ready;

  always @(negedge clk) begin
    if (took_result)
      stall_left = out_calm ? 0 : $urandom_range(0, 9);
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Presents one item after a random gap and holds it until it is accepted.
  // Valid is only lowered when a gap is drawn, so a run of zero gaps keeps
  // it high across items.
  task automatic push_item(input lps_in_t it);
    int gap;
    gap = in_calm ? 0 : $urandom_range(0, 9);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic push_start(input int sx, input int sy, input int ex, input int ey,
                            input logic [COLOR_W-1:0] color);
    lps_in_t it;
    it.req_type   = REQ_START;
    it.start_x    = COORD_W'(sx);
    it.start_y    = COORD_W'(sy);
    it.end_x      = COORD_W'(ex);
    it.end_y      = COORD_W'(ey);
    it.line_color = color;
    push_item(it);
  endtask

  // Advance items ignore their coordinate and color fields, so those carry
  // random bits to show that they really are ignored.
  task automatic push_advances(input int count);
    logic [95:0] noise;
    lps_in_t     it;
    repeat (count) begin
      noise = {$urandom, $urandom, $urandom};
      it = noise[$bits(lps_in_t)-1:0];
      it.req_type = REQ_ADVANCE;
      push_item(it);
    end
  endtask

  // Drops valid and waits until every result item has come back, then waits
  // out SETTLE_CYCLES more, so that the block is idle before registers are touched.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
  endtask

  // Each phase runs under its own register setting. The first two hold the
  // extremes: base and pitch all ones with address wraparound, then both zero.
  // Bytes-per-pixel values outside one to four are taken as a plain multiplier.
  task automatic load_config(input int phase);
    case (phase)
      0: begin
        write_reg(CFG_FB_BASE, 32'hFFFF_FFFF);
        write_reg(CFG_ROW_PITCH, 32'h0000_FFFF);
        write_reg(CFG_BPP, 32'd4);
      end
      1: begin
        write_reg(CFG_FB_BASE, 32'd0);
        write_reg(CFG_ROW_PITCH, 32'd0);
        write_reg(CFG_BPP, 32'd1);
      end
      2: begin
        write_reg(CFG_FB_BASE, $urandom);
        write_reg(CFG_ROW_PITCH, $urandom_range(0, 16'hFFFF));
        write_reg(CFG_BPP, {16'($urandom_range(0, 16'hFFFF)), 16'h0} & ~32'h7);
      end
      3: begin
        write_reg(CFG_SPARE_IDX, $urandom);
        write_reg(CFG_FB_BASE, $urandom);
        write_reg(CFG_ROW_PITCH, $urandom_range(0, 16'hFFFF));
        write_reg(CFG_BPP, 32'd7);
        write_reg(CFG_SPARE_IDX, $urandom);
      end
      4: begin
        write_reg(CFG_FB_BASE, 32'h1000_0000);
        write_reg(CFG_ROW_PITCH, 32'd16384);
        write_reg(CFG_BPP, 32'd4);
      end
      default: begin
        // Upper bits of the write data lie outside the narrow registers.
        write_reg(CFG_FB_BASE, $urandom);
        write_reg(CFG_ROW_PITCH, $urandom);
        write_reg(CFG_BPP, $urandom);
      end
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic int clip_coord(input int v);
    if (v < 0)
      return 0;
    if (v > COORD_MAX)
      return COORD_MAX;
    return v;
  endfunction

  // One random line: mostly short lines walked to their end, sometimes with
  // a few advances past the end, sometimes abandoned by the next start.
  // Long lines across the whole screen are always cut short.
  task automatic draw_line();
    int sx, sy, ex, ey, span, dx, dy, len, steps;
    logic [95:0] noise;
    lps_in_t stray;
    if ($urandom_range(0, 7) == 0)
      in_calm = ~in_calm;
    if ($urandom_range(0, 7) == 0)
      out_calm = ~out_calm;
    // Now and then a fully random item lands between lines.
    if ($urandom_range(0, 9) == 0) begin
      noise = {$urandom, $urandom, $urandom};
      stray = noise[$bits(lps_in_t)-1:0];
      push_item(stray);
    end
    span = ($urandom_range(0, 7) == 0) ? 60 : 12;
    sx = $urandom_range(0, COORD_MAX);
    sy = $urandom_range(0, COORD_MAX);
    ex = sx;
    ey = sy;
    case ($urandom_range(0, 9))
      0: begin
        ex = $urandom_range(0, COORD_MAX);
        ey = $urandom_range(0, COORD_MAX);
      end
      1: ex = clip_coord(sx + $urandom_range(0, 2 * span) - span);
      2: ey = clip_coord(sy + $urandom_range(0, 2 * span) - span);
      3: ;
      default: begin
        ex = clip_coord(sx + $urandom_range(0, 2 * span) - span);
        ey = clip_coord(sy + $urandom_range(0, 2 * span) - span);
      end
    endcase
    dx = (ex > sx) ? ex - sx : sx - ex;
    dy = (ey > sy) ? ey - sy : sy - ey;
    len = (dx > dy) ? dx : dy;
    if (len > 80)
      steps = $urandom_range(0, 40);
    else if ($urandom_range(0, 9) < 7)
      steps = len + $urandom_range(0, 2);
    else
      steps = $urandom_range(0, len);
    push_start(sx, sy, ex, ey, COLOR_W'($urandom_range(0, 24'hFF_FFFF)));
    push_advances(steps);
  endtask

  initial begin
    int target;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_item   = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_FB_BASE;
    cfg_wdata = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed lines under the reset register values (base 0, pitch 0,
    // three bytes per pixel). An advance right after reset finds no line.
    push_advances(1);
    // Equal endpoints give a zero-length line, so the advance finds none.
    push_start(0, 0, 0, 0, 24'hFF_FFFF);
    push_advances(1);
    // Horizontal line stepping down from the top corner, walked one past its end.
    push_start(COORD_MAX, COORD_MAX, COORD_MAX - 2, COORD_MAX, 24'hAB_CDEF);
    push_advances(3);
    // Vertical line stepping up from the origin.
    push_start(0, 0, 0, 2, 24'h00_0000);
    push_advances(2);
    // X-major line with x falling and y rising.
    push_start(COORD_MAX, 0, COORD_MAX - 3, 2, 24'h12_3456);
    push_advances(3);
    // Y-major line with y falling.
    push_start(0, COORD_MAX, 1, COORD_MAX - 4, 24'h80_0001);
    push_advances(4);
    // Full-screen diagonal, abandoned by a start of the opposite diagonal.
    push_start(0, 0, COORD_MAX, COORD_MAX, 24'h5A_A55A);
    push_advances(2);
    push_start(COORD_MAX, 0, 0, COORD_MAX, 24'hA5_5AA5);
    push_advances(1);

    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      load_config(phase);
      target = items_sent + ITEMS_PER_PHASE;
      while (items_sent < target)
        draw_line();
    end
    settle();

    if (fail_count == 0 && pending == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
